[rtl/pip_pkg.sv]
// shared types and codes for the point-in-polygon winding block
package pip_pkg;

	localparam int FIELD_W = 32;

	typedef enum logic [1:0] {
		LOC_OUTSIDE = 2'd0,
		LOC_INSIDE  = 2'd1,
		LOC_ON_EDGE = 2'd2
	} location_t;

	typedef struct packed {
		logic first;
		logic last;
		logic skip;
		logic half;
		logic up;
		logic down;
	} edge_flags_t;

endpackage

[rtl/pip_edge.sv]
// edge stage: vertex differences, the two cross products and the span tests
module pip_edge #(
	parameter int CW = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ld,
	input  logic                       drop,
	input  logic signed [CW-1:0]       ax,
	input  logic signed [CW-1:0]       ay,
	input  logic signed [CW-1:0]       bx,
	input  logic signed [CW-1:0]       by,
	input  logic signed [CW-1:0]       qx,
	input  logic signed [CW-1:0]       qy,
	input  logic                       first,
	input  logic                       last,
	output logic                       s2_v,
	output logic signed [2*CW+1:0]     p1_s2,
	output logic signed [2*CW+1:0]     p2_s2,
	output pip_pkg::edge_flags_t       flags_s2
);

	localparam int DW = CW + 1;
	localparam int PW = 2 * CW + 2;

	logic signed [DW-1:0] dqx, dby, dbx, dqy;
	logic signed [PW-1:0] dqx_w, dby_w, dbx_w, dqy_w;
	logic signed [PW-1:0] p1, p2;
	pip_pkg::edge_flags_t flags;
	logic                 s2_v_q;

	assign dqx = DW'(qx) - DW'(ax);
	assign dby = DW'(by) - DW'(ay);
	assign dbx = DW'(bx) - DW'(ax);
	assign dqy = DW'(qy) - DW'(ay);

	assign dqx_w = PW'(dqx);
	assign dby_w = PW'(dby);
	assign dbx_w = PW'(dbx);
	assign dqy_w = PW'(dqy);

	assign p1 = dqx_w * dby_w;
	assign p2 = dbx_w * dqy_w;

	always_comb begin
		flags.first = first;
		flags.last  = last;
		flags.skip  = (ax == bx && ay == by) ||
			(qy > ay && qy > by) || (qy < ay && qy < by);
		flags.half  = (ax <= qx && qx < bx) || (ax >= qx && qx > bx) ||
			(ay <= qy && qy < by) || (ay >= qy && qy > by);
		flags.up    = ay < qy && qy <= by;
		flags.down  = by <= qy && qy < ay;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (ld) begin
			s2_v_q <= 1'b1;
		end else if (drop) begin
			s2_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			p1_s2    <= p1;
			p2_s2    <= p2;
			flags_s2 <= flags;
		end
	end

	assign s2_v = s2_v_q;

endmodule

[rtl/pip_wind.sv]
// winding stage: cross product sign, saturating count, edge hit and result register
module pip_wind #(
	parameter int CW   = 32,
	parameter int MAXV = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s2_v,
	input  logic signed [2*CW+1:0] p1_s2,
	input  logic signed [2*CW+1:0] p2_s2,
	input  pip_pkg::edge_flags_t   flags_s2,
	input  logic                   out_ready,
	output logic                   s2_go,
	output logic                   out_valid,
	output logic [1:0]             location
);

	localparam int SW    = 2 * CW + 3;
	localparam int CNT_W = $clog2(MAXV) + 1;
	localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(MAXV - 1);
	localparam logic signed [CNT_W-1:0] CNT_MIN = CNT_W'(-MAXV);

	logic signed [SW-1:0]    s;
	logic                    s_zero, s_neg;
	logic signed [CNT_W-1:0] count_q, base_count, nxt_count;
	logic                    hit_q, base_hit, nxt_hit;
	logic                    out_v_q, out_free;
	pip_pkg::location_t      loc_q, nxt_loc;

	assign s      = SW'(p1_s2) - SW'(p2_s2);
	assign s_zero = (s == '0);
	assign s_neg  = s[SW-1];

	always_comb begin
		base_count = flags_s2.first ? '0 : count_q;
		base_hit   = flags_s2.first ? 1'b0 : hit_q;
		nxt_count  = base_count;
		nxt_hit    = base_hit;
		if (!flags_s2.first && !base_hit && !flags_s2.skip) begin
			if (s_zero && flags_s2.half) begin
				nxt_hit = 1'b1;
			end else if (s_neg && flags_s2.up) begin
				if (base_count < CNT_MAX) begin
					nxt_count = base_count + CNT_W'(1);
				end
			end else if (!s_neg && !s_zero && flags_s2.down) begin
				if (base_count > CNT_MIN) begin
					nxt_count = base_count - CNT_W'(1);
				end
			end
		end
		if (nxt_hit) begin
			nxt_loc = pip_pkg::LOC_ON_EDGE;
		end else if (nxt_count != '0) begin
			nxt_loc = pip_pkg::LOC_INSIDE;
		end else begin
			nxt_loc = pip_pkg::LOC_OUTSIDE;
		end
	end

	assign out_free = !out_v_q || out_ready;
	assign s2_go    = s2_v && (!flags_s2.last || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hit_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s2_go) begin
				count_q <= flags_s2.last ? '0 : nxt_count;
				hit_q   <= flags_s2.last ? 1'b0 : nxt_hit;
			end
			if (s2_go && flags_s2.last) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && flags_s2.last) begin
			loc_q <= nxt_loc;
		end
	end

	assign out_valid = out_v_q;
	assign location  = loc_q;

endmodule

[rtl/point_in_polygon_winding.sv]
// top level of the streaming winding-number point-in-polygon test
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   in      | in_valid / in_ready  | vertex_x, vertex_y, query_x, query_y, last_vertex
//   out     | out_valid / out_ready| location
//
// one item per cycle while no result is stalled; three register stages from input to result
// (input register, cross product register, result register)
// out_valid rises once the last vertex has passed the input and cross product registers
// the two cross products in the edge stage set the cycle time
// reset clears the ring state, count and all valid bits
// a stalled result holds only the last vertex behind it; items after that vertex wait behind it
module point_in_polygon_winding #(
	parameter int MAX_RING_VERTICES = 65536,
	parameter int COORD_WIDTH       = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pip_pkg::FIELD_W-1:0]  vertex_x,
	input  logic signed [pip_pkg::FIELD_W-1:0]  vertex_y,
	input  logic signed [pip_pkg::FIELD_W-1:0]  query_x,
	input  logic signed [pip_pkg::FIELD_W-1:0]  query_y,
	input  logic                                last_vertex,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          location
);

	localparam int CW = COORD_WIDTH;
	localparam int FW = pip_pkg::FIELD_W;

	logic signed [CW-1:0] vx_c, vy_c, qx_c, qy_c;
	logic signed [CW-1:0] prev_x_q, prev_y_q, hq_x_q, hq_y_q;
	logic                 in_ring_q;
	logic signed [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1, qx_s1, qy_s1;
	logic                 first_s1, last_s1, s1_v_q;
	logic                 accept, s1_go, s2_v, s2_go, s2_free;
	logic signed [2*CW+1:0] p1_s2, p2_s2;
	pip_pkg::edge_flags_t   flags_s2;

	generate
		if (CW <= FW) begin : g_narrow
			assign vx_c = vertex_x[CW-1:0];
			assign vy_c = vertex_y[CW-1:0];
			assign qx_c = query_x[CW-1:0];
			assign qy_c = query_y[CW-1:0];
		end else begin : g_wide
			assign vx_c = {{(CW-FW){1'b0}}, vertex_x};
			assign vy_c = {{(CW-FW){1'b0}}, vertex_y};
			assign qx_c = {{(CW-FW){1'b0}}, query_x};
			assign qy_c = {{(CW-FW){1'b0}}, query_y};
		end
	endgenerate

	assign accept   = in_valid && in_ready;
	assign s2_free  = !s2_v || s2_go;
	assign s1_go    = s1_v_q && s2_free;
	assign in_ready = !s1_v_q || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ring_q <= 1'b0;
			s1_v_q    <= 1'b0;
		end else begin
			if (accept) begin
				in_ring_q <= !last_vertex;
				s1_v_q    <= 1'b1;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_s1    <= prev_x_q;
			ay_s1    <= prev_y_q;
			bx_s1    <= vx_c;
			by_s1    <= vy_c;
			qx_s1    <= in_ring_q ? hq_x_q : qx_c;
			qy_s1    <= in_ring_q ? hq_y_q : qy_c;
			first_s1 <= !in_ring_q;
			last_s1  <= last_vertex;
			prev_x_q <= vx_c;
			prev_y_q <= vy_c;
			if (!in_ring_q) begin
				hq_x_q <= qx_c;
				hq_y_q <= qy_c;
			end
		end
	end

	pip_edge #(
		.CW(CW)
	) u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (s1_go),
		.drop     (s2_go),
		.ax       (ax_s1),
		.ay       (ay_s1),
		.bx       (bx_s1),
		.by       (by_s1),
		.qx       (qx_s1),
		.qy       (qy_s1),
		.first    (first_s1),
		.last     (last_s1),
		.s2_v     (s2_v),
		.p1_s2    (p1_s2),
		.p2_s2    (p2_s2),
		.flags_s2 (flags_s2)
	);

	pip_wind #(
		.CW   (CW),
		.MAXV (MAX_RING_VERTICES)
	) u_wind (
		.clk       (clk),
		.arst_n    (arst_n),
		.s2_v      (s2_v),
		.p1_s2     (p1_s2),
		.p2_s2     (p2_s2),
		.flags_s2  (flags_s2),
		.out_ready (out_ready),
		.s2_go     (s2_go),
		.out_valid (out_valid),
		.location  (location)
	);

endmodule
